[src/sdr_pkg.sv]
// Shared types, codes and defaults for the shortest-path relaxation engine.
// Depends on nothing; sdr_front, sdr_queue, sdr_back and the top level import it.
package sdr_pkg;

  localparam int unsigned DefMaxLocalVertices = 1024;
  localparam int unsigned DefMaxDegree        = 32;
  localparam int unsigned DefMaxParts         = 8;
  localparam int unsigned QueueDepth          = 4;

  localparam logic [30:0] DistMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_BOUND = 2'd1,
    CMD_RELAX = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_BOUND = 2'd1,
    OP_RELAX = 2'd2,
    OP_ERR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_SAME    = 3'd2,
    KIND_NOEDGE  = 3'd3,
    KIND_SEND    = 3'd4,
    KIND_DROP    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_LOCAL_BASE   = 2'd0,
    REG_VERTEX_LIMIT = 2'd1,
    REG_NUM_PARTS    = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [30:0] vertex;
    logic [30:0] neighbor;
    logic [15:0] weight;
    logic [30:0] distance;
    logic [2:0]  slot;
  } op_t;

  typedef struct packed {
    logic [30:0] local_base;
    logic [30:0] vertex_limit;
    logic [3:0]  num_parts;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] target;
    logic [30:0] new_dist;
    logic [2:0]  part;
    logic        last;
  } result_t;

endpackage

[src/sdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[src/sdr_front.sv]
// Front end: accepts input items and classifies them into operations.
// Depends on sdr_pkg.
module sdr_front import sdr_pkg::*; #(
  parameter int unsigned MAX_LOCAL_VERTICES = DefMaxLocalVertices,
  parameter int unsigned MAX_PARTS          = DefMaxParts
) (
  input  cfg_t        cfg_i,
  input  logic [1:0]  cmd_i,
  input  logic [30:0] vertex_i,
  input  logic [30:0] neighbor_i,
  input  logic [15:0] weight_i,
  input  logic [30:0] distance_i,
  input  logic [2:0]  slot_i,
  output op_t         op_o
);

  logic [30:0] diff;
  logic        is_local;

  assign diff     = vertex_i - cfg_i.local_base;
  assign is_local = (vertex_i >= cfg_i.local_base) && (diff < 31'(MAX_LOCAL_VERTICES));

  always_comb begin
    op_o.vertex   = vertex_i;
    op_o.neighbor = neighbor_i;
    op_o.weight   = weight_i;
    op_o.distance = distance_i;
    op_o.slot     = slot_i;
    unique case (cmd_e'(cmd_i))
      CMD_EDGE:  op_o.op = is_local ? OP_EDGE : OP_ERR;
      CMD_BOUND: op_o.op = ({1'b0, slot_i} < 4'(MAX_PARTS)) ? OP_BOUND : OP_ERR;
      CMD_RELAX: op_o.op = is_local ? OP_RELAX : OP_ERR;
      default:   op_o.op = OP_ERR;
    endcase
  end

endmodule

[src/sdr_queue.sv]
// Short operation queue between the front end and the back end.
// Depends on sdr_pkg.
module sdr_queue import sdr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

[src/sdr_back.sv]
// Back end: executes queued operations against the vertex, edge and boundary stores.
// Depends on sdr_pkg and sdr_ram.
module sdr_back import sdr_pkg::*; #(
  parameter int unsigned MAX_LOCAL_VERTICES = DefMaxLocalVertices,
  parameter int unsigned MAX_DEGREE         = DefMaxDegree,
  parameter int unsigned MAX_PARTS          = DefMaxParts
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_valid_i,
  input  op_t     q_data_i,
  output logic    q_pop_o,
  output logic    clearing_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  localparam int unsigned LiW = $clog2(MAX_LOCAL_VERTICES);
  localparam int unsigned DgW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned EaW = $clog2(MAX_LOCAL_VERTICES * MAX_DEGREE);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DEC   = 6'b000100,
    ST_EREAD = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_SPARE = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  op_t             op_q, op_d;
  logic [LiW-1:0]  idx_q, idx_d, clr_q, clr_d;
  logic [DgW-1:0]  k_q, k_d, deg_q, deg_d;
  logic [EaW-1:0]  base_q, base_d;
  logic [30:0]     bt_q [MAX_PARTS];
  logic            bt_we;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic            out_free;

  logic            dist_we, dist_re, deg_we, edge_we, edge_re;
  logic [LiW-1:0]  vwaddr;
  logic [30:0]     dist_wdata, dist_rdata, et_rdata;
  logic [DgW-1:0]  deg_wdata, deg_rdata;
  logic [15:0]     ew_rdata;
  logic [EaW-1:0]  e_waddr, e_raddr;
  logic [30:0]     q_diff;
  logic [31:0]     nd_sum;
  logic [30:0]     nd;
  logic [3:0]      parts;
  logic [2:0]      part;
  logic            run;

  assign out_free    = !out_valid_q || res_ready_i;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign q_diff      = q_data_i.vertex - cfg_i.local_base;
  assign e_waddr     = EaW'(idx_q) * EaW'(MAX_DEGREE) + EaW'(deg_rdata);
  assign e_raddr     = base_q + EaW'(k_q);
  assign nd_sum      = {1'b0, op_q.distance} + 32'(ew_rdata);
  assign nd          = nd_sum[31] ? DistMax : nd_sum[30:0];

  always_comb begin
    if (cfg_i.num_parts == 4'd0) begin
      parts = 4'd1;
    end else if (cfg_i.num_parts > 4'(MAX_PARTS)) begin
      parts = 4'(MAX_PARTS);
    end else begin
      parts = cfg_i.num_parts;
    end
    part = 3'd0;
    run  = 1'b1;
    for (int j = 1; j < MAX_PARTS; j++) begin
      if (run && (4'(j) < parts) && (et_rdata >= bt_q[j])) begin
        part = part + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    k_d         = k_q;
    deg_d       = deg_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    dist_we     = 1'b0;
    deg_we      = 1'b0;
    edge_we     = 1'b0;
    edge_re     = 1'b0;
    dist_re     = 1'b0;
    bt_we       = 1'b0;
    vwaddr      = idx_q;
    dist_wdata  = op_q.distance;
    deg_wdata   = deg_rdata + DgW'(1);
    unique case (state_q)
      ST_CLEAR: begin
        dist_we    = 1'b1;
        deg_we     = 1'b1;
        vwaddr     = clr_q;
        dist_wdata = DistMax;
        deg_wdata  = '0;
        clr_d      = clr_q + LiW'(1);
        if (clr_q == LiW'(MAX_LOCAL_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          dist_re = 1'b1;
          op_d    = q_data_i;
          idx_d   = q_diff[LiW-1:0];
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_ACK, target: '0, new_dist: '0, part: '0, last: 1'b1};
          state_d     = ST_IDLE;
          unique case (op_q.op)
            OP_ERR: out_d.kind = KIND_ERROR;
            OP_BOUND: bt_we = 1'b1;
            OP_EDGE: begin
              if (deg_rdata >= DgW'(MAX_DEGREE)) begin
                out_d.kind = KIND_ERROR;
              end else begin
                edge_we = 1'b1;
                deg_we  = 1'b1;
              end
            end
            OP_RELAX: begin
              out_d.target = op_q.vertex;
              if (op_q.distance >= dist_rdata) begin
                out_d.kind     = KIND_SAME;
                out_d.new_dist = dist_rdata;
              end else begin
                dist_we = 1'b1;
                if (deg_rdata == '0) begin
                  out_d.kind     = KIND_NOEDGE;
                  out_d.new_dist = op_q.distance;
                end else begin
                  out_valid_d = out_valid_q && !res_ready_i;
                  k_d         = '0;
                  deg_d       = (deg_rdata > DgW'(MAX_DEGREE)) ? DgW'(MAX_DEGREE)
                                                               : deg_rdata;
                  base_d      = EaW'(idx_q) * EaW'(MAX_DEGREE);
                  state_d     = ST_EREAD;
                end
              end
            end
            default: out_d.kind = KIND_ERROR;
          endcase
        end
      end
      ST_EREAD: begin
        edge_re = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.target   = et_rdata;
          out_d.new_dist = nd;
          out_d.last     = (k_q + DgW'(1) == deg_q);
          if (et_rdata < cfg_i.vertex_limit) begin
            out_d.kind = KIND_SEND;
            out_d.part = part;
          end else begin
            out_d.kind = KIND_DROP;
            out_d.part = '0;
          end
          k_d     = k_q + DgW'(1);
          state_d = (k_q + DgW'(1) == deg_q) ? ST_IDLE : ST_EREAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_PARTS; i++) begin
        bt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (bt_we) begin
        bt_q[op_q.slot] <= op_q.vertex;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    k_q    <= k_d;
    deg_q  <= deg_d;
    base_q <= base_d;
    out_q  <= out_d;
  end

  sdr_ram #(.WIDTH(31), .DEPTH(MAX_LOCAL_VERTICES)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(vwaddr), .wdata_i(dist_wdata),
    .re_i(dist_re), .raddr_i(q_diff[LiW-1:0]), .rdata_o(dist_rdata)
  );

  sdr_ram #(.WIDTH(DgW), .DEPTH(MAX_LOCAL_VERTICES)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(vwaddr), .wdata_i(deg_wdata),
    .re_i(dist_re), .raddr_i(q_diff[LiW-1:0]), .rdata_o(deg_rdata)
  );

  sdr_ram #(.WIDTH(31), .DEPTH(MAX_LOCAL_VERTICES * MAX_DEGREE)) u_etgt (
    .clk_i, .we_i(edge_we), .waddr_i(e_waddr), .wdata_i(op_q.neighbor),
    .re_i(edge_re), .raddr_i(e_raddr), .rdata_o(et_rdata)
  );

  sdr_ram #(.WIDTH(16), .DEPTH(MAX_LOCAL_VERTICES * MAX_DEGREE)) u_ewgt (
    .clk_i, .we_i(edge_we), .waddr_i(e_waddr), .wdata_i(op_q.weight),
    .re_i(edge_re), .raddr_i(e_raddr), .rdata_o(ew_rdata)
  );

endmodule

[src/sssp_distance_relaxation_top.sv]
// Top level of the shortest-path relaxation engine: configuration registers and stream ports.
// Depends on sdr_pkg, sdr_front, sdr_queue and sdr_back.
//
//   Channel   Direction  Transfer when
//   s_axis    in         s_axis_tvalid and s_axis_tready
//   m_axis    out        m_axis_tvalid and m_axis_tready
//   apb       in         psel, penable, pwrite and pready (write)
//
// A load or rejected item passes through the idle and decode states of the back end.
// A relax item with edges then runs an edge-read and an emit state per edge, one edge-store read each.
// After reset a clearing pass over all MAX_LOCAL_VERTICES vertex entries runs before the first transfer in.
// The queue keeps accepting, until it is full, while the output register waits on m_axis_tready.
module sssp_distance_relaxation_top import sdr_pkg::*; #(
  parameter int unsigned MAX_LOCAL_VERTICES = DefMaxLocalVertices,
  parameter int unsigned MAX_DEGREE         = DefMaxDegree,
  parameter int unsigned MAX_PARTS          = DefMaxParts
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex[30:0], neighbor[61:31], weight[77:62], distance[108:78], boundary_slot[111:109]
  input  logic [111:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // target_vertex[30:0], new_distance[61:31], dest_part[64:62], zeros above
  output logic [71:0]  m_axis_tdata,
  // kind[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg_q;
  op_t     f_op, q_op;
  logic    q_full, q_valid, q_pop, clearing;
  result_t res;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_base   <= '0;
      cfg_q.vertex_limit <= '0;
      cfg_q.num_parts    <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_e'(paddr[3:2]))
        REG_LOCAL_BASE:   cfg_q.local_base   <= pwdata[30:0];
        REG_VERTEX_LIMIT: cfg_q.vertex_limit <= pwdata[30:0];
        REG_NUM_PARTS:    cfg_q.num_parts    <= pwdata[3:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_LOCAL_BASE:   prdata = {1'b0, cfg_q.local_base};
      REG_VERTEX_LIMIT: prdata = {1'b0, cfg_q.vertex_limit};
      REG_NUM_PARTS:    prdata = {28'd0, cfg_q.num_parts};
      default:          prdata = '0;
    endcase
  end

  assign s_axis_tready = !q_full && !clearing;

  sdr_front #(
    .MAX_LOCAL_VERTICES(MAX_LOCAL_VERTICES),
    .MAX_PARTS         (MAX_PARTS)
  ) u_front (
    .cfg_i     (cfg_q),
    .cmd_i     (s_axis_tuser),
    .vertex_i  (s_axis_tdata[30:0]),
    .neighbor_i(s_axis_tdata[61:31]),
    .weight_i  (s_axis_tdata[77:62]),
    .distance_i(s_axis_tdata[108:78]),
    .slot_i    (s_axis_tdata[111:109]),
    .op_o      (f_op)
  );

  sdr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (s_axis_tvalid && s_axis_tready),
    .data_i (f_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_op)
  );

  sdr_back #(
    .MAX_LOCAL_VERTICES(MAX_LOCAL_VERTICES),
    .MAX_DEGREE        (MAX_DEGREE),
    .MAX_PARTS         (MAX_PARTS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_data_i   (q_op),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, res.part, res.new_dist, res.target};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready) else $error("input accepted during clearing pass");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= KIND_DROP)) else $error("result kind out of range");

  a_part_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_SEND)) |-> (m_axis_tdata[64:62] == 3'd0))
    else $error("destination partition set on a non-send result");

  a_single_results_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == KIND_ACK) || (m_axis_tuser == KIND_ERROR)))
      |-> m_axis_tlast) else $error("single result without last");

endmodule
